[design/shifted_chebyshev_eval_deriv_top_assert.svh]
// assertion macros for the shifted chebyshev evaluator
`ifndef SHIFTED_CHEBYSHEV_EVAL_DERIV_TOP_ASSERT_SVH
`define SHIFTED_CHEBYSHEV_EVAL_DERIV_TOP_ASSERT_SVH

// same-cycle implication, checked on clk_i, off while rst_ni is low
`define SCED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off while rst_ni is low
`define SCED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sced_pkg.sv]
// shared types and constants of the shifted chebyshev evaluator
`timescale 1ns / 1ps

package sced_pkg;

  // highest degree ever evaluated, whatever the order register holds
  localparam int MAX_ORDER = 31;

  localparam int X_W      = 25;
  localparam int Z_W      = 25;
  localparam int VAL_W    = 32;
  localparam int SLOPE_W  = 42;
  localparam int TERM_W   = 5;
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = Z_W + MUL_B_W;
  localparam int QUOT_W   = 42;
  localparam int DCNT_W   = $clog2(QUOT_W);

  localparam logic [X_W-1:0]            X_ONE     = 25'd16777216;
  localparam logic [X_W-1:0]            Z_HALF    = 25'd8388608;
  localparam logic signed [VAL_W-1:0]   VAL_ONE   = 32'sd1073741824;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 42'sd2063731785728;
  localparam logic signed [SLOPE_W-1:0] D_TWO     = 42'sd2147483648;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_MUL_U,
    ST_MUL_DL,
    ST_MUL_DH,
    ST_MUL_END,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_SIGN,
    DIV_DONE
  } div_state_e;

endpackage

[design/shifted_chebyshev_eval_deriv_top.sv]
// top level: shifted chebyshev values and slopes by recurrence, one beat per degree
`timescale 1ns / 1ps

// Takes a point x (unsigned Q1.24, values above 1.0 read as 1.0) and emits one
// output beat per degree n = 0..p, p being the order register clamped to
// MAX_ORDER: T_n(2x-1) with 30 fraction bits and its x-slope with 30 fraction
// bits, both saturated, tlast on degree p. Degrees 0 and 1 need no multiplier
// or divider pass; every higher degree takes three passes through the shared
// z multiplier and then the 42-step bit-serial divider that forms z*d(n)/n,
// and each beat may be held back by output stalls.
// A new x is taken once the beat for degree p sits in the output register;
// that beat may still wait for m_axis_tready meanwhile. The order register is
// written over its own valid/ready channel, always ready, and is to be
// changed only while no item is in flight.

module shifted_chebyshev_eval_deriv_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // order register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [24:0] x, [31:25] zero
  // output beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [4:0] term_index, [36:5] value, [78:37] slope, [79] zero
  output logic        m_axis_tlast
);

  localparam int VW = sced_pkg::VAL_W;
  localparam int SW = sced_pkg::SLOPE_W;
  localparam int TW = sced_pkg::TERM_W;
  localparam int PW = sced_pkg::PROD_W;
  localparam int QW = sced_pkg::QUOT_W;

  localparam logic signed [36:0] U_HI  = 37'sd1073741824;
  localparam logic signed [36:0] U_LO  = -37'sd1073741824;
  localparam logic signed [48:0] SL_HI = 49'sd2063731785728;
  localparam logic signed [48:0] SL_LO = -49'sd2063731785728;

  sced_pkg::seq_state_e state_q, state_d;

  logic [TW-1:0]                  order_q;
  logic [TW-1:0]                  p_q, p_d;
  logic [TW-1:0]                  n_q, n_d;
  logic signed [sced_pkg::Z_W-1:0] z_q, z_d;
  logic signed [VW-1:0]           u_prev_q, u_prev_d;
  logic signed [VW-1:0]           u_cur_q, u_cur_d;
  logic signed [VW-1:0]           u_nx_q, u_nx_d;
  logic signed [SW-1:0]           d_cur_q, d_cur_d;
  logic signed [43:0]             acc_q, acc_d;
  logic signed [42:0]             s_q, s_d;

  logic                           out_valid_q, out_valid_d;
  logic [TW-1:0]                  out_term_q, out_term_d;
  logic signed [VW-1:0]           out_value_q, out_value_d;
  logic signed [SW-1:0]           out_slope_q, out_slope_d;
  logic                           out_last_q, out_last_d;

  logic [sced_pkg::X_W-1:0]           x_clamped;
  logic signed [sced_pkg::Z_W-1:0]    z_in;
  logic [TW-1:0]                      p_eff;
  logic                               slot_free;
  logic signed [sced_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod;
  logic signed [36:0]                 u_diff;
  logic signed [VW-1:0]               u_sat;
  logic signed [48:0]                 sl_prod;
  logic signed [SW-1:0]               sl_sat;
  logic                               div_start;
  logic                               div_done;
  logic signed [QW-1:0]               div_quot;
  logic                               out_value_ok;
  logic                               out_slope_ok;
  logic                               emit_fire;

  // order register, always ready
  assign cfg_ready_o = 1'b1;

  // z = 2x - 1 exactly, 23 fraction bits
  assign x_clamped = (s_axis_tdata[sced_pkg::X_W-1:0] > sced_pkg::X_ONE)
                     ? sced_pkg::X_ONE : s_axis_tdata[sced_pkg::X_W-1:0];
  assign z_in      = $signed(x_clamped - sced_pkg::Z_HALF);
  assign p_eff     = (6'(order_q) > 6'(sced_pkg::MAX_ORDER))
                     ? TW'(sced_pkg::MAX_ORDER) : order_q;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == sced_pkg::ST_IDLE);

  sced_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (z_q),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  sced_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q[QW-1:0]),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // value step: floor(2*z*u/2^30) - u_prev, clipped to +-1.0
  assign u_diff = $signed({prod[PW-1], prod[PW-1:22]})
                - $signed({{5{u_prev_q[VW-1]}}, u_prev_q});
  assign u_sat  = (u_diff > U_HI) ? sced_pkg::VAL_ONE
                : (u_diff < U_LO) ? -sced_pkg::VAL_ONE
                : u_diff[VW-1:0];

  // slope step: (n+1) * (q + 2u), clipped
  assign sl_prod = 49'(s_q) * 49'($signed({1'b0, n_q + 5'd1}));
  assign sl_sat  = (sl_prod > SL_HI) ? sced_pkg::SLOPE_MAX
                 : (sl_prod < SL_LO) ? -sced_pkg::SLOPE_MAX
                 : sl_prod[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sced_pkg::ST_IDLE;
      order_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    n_q         <= n_d;
    z_q         <= z_d;
    u_prev_q    <= u_prev_d;
    u_cur_q     <= u_cur_d;
    u_nx_q      <= u_nx_d;
    d_cur_q     <= d_cur_d;
    acc_q       <= acc_d;
    s_q         <= s_d;
    out_term_q  <= out_term_d;
    out_value_q <= out_value_d;
    out_slope_q <= out_slope_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    n_d         = n_q;
    z_d         = z_q;
    u_prev_d    = u_prev_q;
    u_cur_d     = u_cur_q;
    u_nx_d      = u_nx_q;
    d_cur_d     = d_cur_q;
    acc_d       = acc_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_term_d  = out_term_q;
    out_value_d = out_value_q;
    out_slope_d = out_slope_q;
    out_last_d  = out_last_q;
    mul_b       = '0;
    div_start   = 1'b0;
    case (state_q)
      sced_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          p_d     = p_eff;
          z_d     = z_in;
          n_d     = '0;
          u_cur_d = sced_pkg::VAL_ONE;
          d_cur_d = '0;
          state_d = sced_pkg::ST_EMIT;
        end
      end
      sced_pkg::ST_EMIT: begin
        // hand degree n to the output register, then advance
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_term_d  = n_q;
          out_value_d = u_cur_q;
          out_slope_d = d_cur_q;
          out_last_d  = (n_q == p_q);
          if (n_q == p_q) begin
            state_d = sced_pkg::ST_IDLE;
          end else if (n_q == '0) begin
            // degree one is z itself, slope 2.0
            u_prev_d = u_cur_q;
            u_cur_d  = $signed({z_q, 7'b0});
            d_cur_d  = sced_pkg::D_TWO;
            n_d      = 5'd1;
          end else begin
            state_d = sced_pkg::ST_MUL_U;
          end
        end
      end
      sced_pkg::ST_MUL_U: begin
        mul_b   = {u_cur_q[VW-1], u_cur_q};
        state_d = sced_pkg::ST_MUL_DL;
      end
      sced_pkg::ST_MUL_DL: begin
        // low 23 bits of the slope, unsigned
        mul_b   = {10'b0, d_cur_q[22:0]};
        u_nx_d  = u_sat;
        state_d = sced_pkg::ST_MUL_DH;
      end
      sced_pkg::ST_MUL_DH: begin
        mul_b   = {{14{d_cur_q[SW-1]}}, d_cur_q[SW-1:23]};
        acc_d   = {{9{prod[PW-1]}}, prod[PW-1:23]};
        state_d = sced_pkg::ST_MUL_END;
      end
      sced_pkg::ST_MUL_END: begin
        // floor(z*d / 2^23) = z*d_hi + floor(z*d_lo / 2^23)
        acc_d   = acc_q + prod[43:0];
        state_d = sced_pkg::ST_DIV_GO;
      end
      sced_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = sced_pkg::ST_DIV;
      end
      sced_pkg::ST_DIV: begin
        if (div_done) begin
          s_d     = {div_quot[QW-1], div_quot} + {{10{u_cur_q[VW-1]}}, u_cur_q, 1'b0};
          state_d = sced_pkg::ST_FIN;
        end
      end
      sced_pkg::ST_FIN: begin
        d_cur_d  = sl_sat;
        u_prev_d = u_cur_q;
        u_cur_d  = u_nx_q;
        n_d      = n_q + 5'd1;
        state_d  = sced_pkg::ST_EMIT;
      end
      default: begin
        state_d = sced_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_slope_q, out_value_q, out_term_q};
  assign m_axis_tlast  = out_last_q;

  // range flags of the waiting beat, and a beat handed over this cycle
  assign out_value_ok = (out_value_q <= sced_pkg::VAL_ONE)
                     && (out_value_q >= -sced_pkg::VAL_ONE);
  assign out_slope_ok = (out_slope_q <= sced_pkg::SLOPE_MAX)
                     && (out_slope_q >= -sced_pkg::SLOPE_MAX);
  assign emit_fire    = (state_q == sced_pkg::ST_EMIT) && slot_free;

`include "shifted_chebyshev_eval_deriv_top_assert.svh"

  // a waiting beat never carries a value outside +-1.0
  `SCED_ASSERT_NOW(a_value_range, m_axis_tvalid, out_value_ok, "value beyond saturation range")
  // nor a slope outside its clip
  `SCED_ASSERT_NOW(a_slope_range, m_axis_tvalid, out_slope_ok, "slope beyond saturation range")
  // the divider is only started for degrees of one and up
  `SCED_ASSERT_NOW(a_div_nonzero, div_start, n_q != 5'd0, "divider started with zero degree")
  // a beat handed over in the emit state shows up on the port
  `SCED_ASSERT_NEXT(a_emit_shows, emit_fire, m_axis_tvalid, "emitted beat not presented")

endmodule

[design/sced_mul.sv]
// shared signed multiplier: z times a selected operand, product registered
`timescale 1ns / 1ps

module sced_mul (
  input  logic                                  clk_i,
  input  logic signed [sced_pkg::Z_W-1:0]       a_i,
  input  logic signed [sced_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [sced_pkg::PROD_W-1:0]    prod_o
);

  logic signed [sced_pkg::PROD_W-1:0] prod_d;
  logic signed [sced_pkg::PROD_W-1:0] prod_q;

  assign prod_d = sced_pkg::PROD_W'(a_i) * sced_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

[design/sced_div.sv]
// bit-serial signed divider by a small degree, truncating toward zero
`timescale 1ns / 1ps

module sced_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [sced_pkg::QUOT_W-1:0]   dividend_i,
  input  logic [sced_pkg::TERM_W-1:0]          divisor_i,
  output logic                                 done_o,
  output logic signed [sced_pkg::QUOT_W-1:0]   quot_o
);

  sced_pkg::div_state_e state_q, state_d;
  logic [sced_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [sced_pkg::QUOT_W-1:0] work_q, work_d;
  logic [sced_pkg::TERM_W-1:0] rem_q, rem_d;
  logic [sced_pkg::TERM_W-1:0] dvs_q, dvs_d;
  logic                        neg_q, neg_d;
  logic [sced_pkg::TERM_W:0]   trial;
  logic                        ge;

  // one quotient bit per cycle, msb first
  assign trial = {rem_q, work_q[sced_pkg::QUOT_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sced_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    work_d  = work_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    case (state_q)
      sced_pkg::DIV_IDLE: begin
        if (start_i) begin
          neg_d   = dividend_i[sced_pkg::QUOT_W-1];
          work_d  = dividend_i[sced_pkg::QUOT_W-1] ? sced_pkg::QUOT_W'(-dividend_i)
                                                   : dividend_i;
          rem_d   = '0;
          dvs_d   = divisor_i;
          cnt_d   = sced_pkg::DCNT_W'(sced_pkg::QUOT_W - 1);
          state_d = sced_pkg::DIV_RUN;
        end
      end
      sced_pkg::DIV_RUN: begin
        rem_d  = ge ? sced_pkg::TERM_W'(trial - {1'b0, dvs_q})
                    : trial[sced_pkg::TERM_W-1:0];
        work_d = {work_q[sced_pkg::QUOT_W-2:0], ge};
        if (cnt_q == '0) begin
          state_d = sced_pkg::DIV_SIGN;
        end else begin
          cnt_d = cnt_q - sced_pkg::DCNT_W'(1);
        end
      end
      sced_pkg::DIV_SIGN: begin
        work_d  = neg_q ? (~work_q + sced_pkg::QUOT_W'(1)) : work_q;
        state_d = sced_pkg::DIV_DONE;
      end
      sced_pkg::DIV_DONE: begin
        state_d = sced_pkg::DIV_IDLE;
      end
      default: begin
        state_d = sced_pkg::DIV_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == sced_pkg::DIV_DONE);
  assign quot_o = $signed(work_q);

endmodule
